/* rtl/rof_pkg.sv */
package rof_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int SYMBOL_BITS    = 8;
  localparam int INDEX_BITS     = 32;
  localparam int LENGTH_BITS    = 16;
  localparam int PLEN_BITS      = 5;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SEARCH_MODE    = 3'd0,
    REG_MIN_RUN        = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_PATTERN_LOW    = 3'd3,
    REG_PATTERN_HIGH   = 3'd4
  } rof_reg_t;

  typedef enum logic {
    MODE_RUN   = 1'b0,
    MODE_EXACT = 1'b1
  } rof_mode_t;

  // Settings as the search logic sees them, already clamped to legal values.
  typedef struct packed {
    rof_mode_t              mode;
    logic [LENGTH_BITS-1:0] need;
    logic [PLEN_BITS-1:0]   plen;
  } rof_cfg_t;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] symbol;
    logic                   first;
    logic                   last;
    logic [INDEX_BITS-1:0]  start_index;
  } rof_item_t;

  typedef struct packed {
    logic                   emit;
    logic                   found;
    logic [INDEX_BITS-1:0]  position;
    logic [LENGTH_BITS-1:0] length;
  } rof_result_t;

endpackage

/* rtl/rof_cfg_regs.sv */
module rof_cfg_regs #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cfg_write,
  input  logic [rof_pkg::CFG_INDEX_BITS-1:0]            cfg_index,
  input  logic [rof_pkg::CFG_DATA_BITS-1:0]             cfg_data,
  output rof_pkg::rof_cfg_t                             cfg,
  output logic [PATTERN_MAX-1:0][rof_pkg::SYMBOL_BITS-1:0] pattern
);
  import rof_pkg::*;

  localparam logic [PLEN_BITS-1:0] PlenMax = PLEN_BITS'(PATTERN_MAX);

  logic [PLEN_BITS-1:0]   plen_raw;
  logic [PLEN_BITS-1:0]   plen_clamped;
  logic [LENGTH_BITS-1:0] run_raw;

  assign plen_raw = cfg_data[PLEN_BITS-1:0];
  assign run_raw  = cfg_data[LENGTH_BITS-1:0];

  always_comb begin
    if (plen_raw == '0) begin
      plen_clamped = PLEN_BITS'(1);
    end else if (plen_raw > PlenMax) begin
      plen_clamped = PlenMax;
    end else begin
      plen_clamped = plen_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= MODE_RUN;
      cfg.need <= LENGTH_BITS'(1);
      cfg.plen <= PLEN_BITS'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SEARCH_MODE:    cfg.mode <= rof_mode_t'(cfg_data[0]);
        REG_MIN_RUN:        cfg.need <= (run_raw == '0) ? LENGTH_BITS'(1) : run_raw;
        REG_PATTERN_LENGTH: cfg.plen <= plen_clamped;
        default: ;
      endcase
    end
  end

  // Characters 0 to 7 come from the low word, 8 to 15 from the high word.
  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_char
    localparam int Off = (g % 8) * SYMBOL_BITS;
    localparam logic [CFG_INDEX_BITS-1:0] Src = (g < 8) ? REG_PATTERN_LOW : REG_PATTERN_HIGH;
    always_ff @(posedge clk) begin
      if (rst) begin
        pattern[g] <= '0;
      end else if (cfg_write && cfg_index == Src) begin
        pattern[g] <= cfg_data[Off +: SYMBOL_BITS];
      end
    end
  end

endmodule

/* rtl/rof_search.sv */
module rof_search #(
  parameter int PATTERN_MAX   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             step,
  input  rof_pkg::rof_item_t                               item,
  input  rof_pkg::rof_cfg_t                                cfg,
  input  logic [PATTERN_MAX-1:0][rof_pkg::SYMBOL_BITS-1:0] pattern,
  output rof_pkg::rof_result_t                             result
);
  import rof_pkg::*;

  localparam int KW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic                     active;
  logic                     active_next;
  logic [POSITION_BITS-1:0] next_index;
  logic [POSITION_BITS-1:0] next_index_next;
  logic [LENGTH_BITS-1:0]   match_count;
  logic [LENGTH_BITS-1:0]   match_count_next;
  logic [POSITION_BITS-1:0] match_begin;
  logic [POSITION_BITS-1:0] match_begin_next;

  logic                     act;
  logic [POSITION_BITS-1:0] idx;
  logic [LENGTH_BITS-1:0]   cnt;
  logic [POSITION_BITS-1:0] beg;
  logic [LENGTH_BITS-1:0]   cnt_inc;
  logic [LENGTH_BITS-1:0]   plen_wide;
  logic [KW-1:0]            k;
  logic [63:0]              start_wide;
  logic [63:0]              begin_wide;

  assign start_wide = 64'(item.start_index);
  assign plen_wide  = LENGTH_BITS'(cfg.plen);

  always_comb begin
    // A first beat restarts the search whether or not one was running.
    act = item.first ? 1'b1 : active;
    idx = item.first ? start_wide[POSITION_BITS-1:0] : next_index;
    cnt = item.first ? '0 : match_count;
    beg = item.first ? '0 : match_begin;

    active_next      = act;
    next_index_next  = idx + POSITION_BITS'(1);
    match_count_next = cnt;
    match_begin_next = beg;
    result           = '0;
    cnt_inc          = (cnt == '1) ? cnt : cnt + LENGTH_BITS'(1);
    k                = (cnt < plen_wide) ? cnt[KW-1:0] : '0;
    begin_wide       = '0;

    if (act) begin
      if (cfg.mode == MODE_RUN) begin
        if (item.symbol == pattern[0]) begin
          if (cnt == '0) begin
            match_begin_next = idx;
          end
          match_count_next = cnt_inc;
          if (item.last && cnt_inc >= cfg.need) begin
            result.emit     = 1'b1;
            result.found    = 1'b1;
            result.length   = cnt_inc;
            begin_wide      = 64'(match_begin_next);
            result.position = begin_wide[INDEX_BITS-1:0];
          end
        end else if (cnt != '0) begin
          match_count_next = '0;
          if (cnt >= cfg.need) begin
            result.emit     = 1'b1;
            result.found    = 1'b1;
            result.length   = cnt;
            begin_wide      = 64'(beg);
            result.position = begin_wide[INDEX_BITS-1:0];
          end
        end
      end else begin
        if (item.symbol == pattern[k]) begin
          if (k == '0) begin
            match_begin_next = idx;
          end
          match_count_next = LENGTH_BITS'(k) + LENGTH_BITS'(1);
        end else if (item.symbol == pattern[0]) begin
          // The breaking character may itself open a new match.
          match_begin_next = idx;
          match_count_next = LENGTH_BITS'(1);
        end else begin
          match_count_next = '0;
        end
        if (match_count_next == plen_wide) begin
          result.emit     = 1'b1;
          result.found    = 1'b1;
          result.length   = plen_wide;
          begin_wide      = 64'(match_begin_next);
          result.position = begin_wide[INDEX_BITS-1:0];
        end
      end

      if (!result.emit && item.last) begin
        result.emit = 1'b1;
      end
      if (result.emit) begin
        active_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      next_index  <= '0;
      match_count <= '0;
      match_begin <= '0;
    end else if (step) begin
      active      <= active_next;
      next_index  <= next_index_next;
      match_count <= match_count_next;
      match_begin <= match_begin_next;
    end
  end

endmodule

/* rtl/run_or_pattern_finder_unit.sv */
// Run-or-pattern finder: scans a character stream for the first run of pattern
// character 0 at least min_run long (run mode) or the first copy of the pattern
// met by a scan without backtracking (exact mode). A beat with first set
// starts a new search at start_index. Input channel: symbol, first, last,
// start_index under in_valid / in_stall. Output channel: found, match_position,
// match_length under out_valid / out_stall. Each search gives at most one beat:
// a hit, or a not-found beat on the last character. After a hit the rest of
// the stream is dropped. Configuration is written through cfg_write /
// cfg_index / cfg_data while the unit is idle.
// Throughput is one character per cycle unless a result waits under out_stall;
// the search state is computed combinationally from the input register. A
// result beat passes through the input register and then the result register.
// When out_stall holds a waiting result, the input register fills and then
// in_stall rises; no beat is lost. Synchronous reset idles the search and
// returns the registers to run mode, min_run 1, pattern length 1, pattern 0.
module run_or_pattern_finder_unit #(
  parameter int PATTERN_MAX   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [rof_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [rof_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rof_pkg::SYMBOL_BITS-1:0]     symbol,
  input  logic                                first,
  input  logic                                last,
  input  logic [rof_pkg::INDEX_BITS-1:0]      start_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                found,
  output logic [rof_pkg::INDEX_BITS-1:0]      match_position,
  output logic [rof_pkg::LENGTH_BITS-1:0]     match_length
);
  import rof_pkg::*;

  rof_cfg_t                               cfg;
  logic [PATTERN_MAX-1:0][SYMBOL_BITS-1:0] pattern;
  rof_item_t                              item;
  logic                                   item_valid;
  rof_result_t                            result;
  logic                                   step;

  rof_cfg_regs #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .pattern   (pattern)
  );

  rof_search #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_search (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .item    (item),
    .cfg     (cfg),
    .pattern (pattern),
    .result  (result)
  );

  // The input register moves on unless a result still waits downstream.
  assign step     = item_valid && !(out_valid && out_stall);
  assign in_stall = item_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.symbol      <= symbol;
      item.first       <= first;
      item.last        <= last;
      item.start_index <= start_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= result.emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.emit) begin
      found          <= result.found;
      match_position <= result.position;
      match_length   <= result.length;
    end
  end

endmodule

/* test/match_checker.sv */
module match_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [rof_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rof_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [rof_pkg::SYMBOL_BITS-1:0]    symbol,
  input  logic                               first,
  input  logic                               last,
  input  logic [rof_pkg::INDEX_BITS-1:0]     start_index,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic                               found,
  input  logic [rof_pkg::INDEX_BITS-1:0]     match_position,
  input  logic [rof_pkg::LENGTH_BITS-1:0]    match_length,
  output int                                 mismatches,
  output int                                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import rof_pkg::*;

  localparam int PATTERN_SLOTS = 16;

  // Shadow copy of the registers and of the search state.
  rof_mode_t               search_kind;
  logic [LENGTH_BITS-1:0]  least_run;
  logic [PLEN_BITS-1:0]    pat_len_reg;
  logic [127:0]            pattern_bytes;
  logic                    searching;
  logic [INDEX_BITS-1:0]   next_pos;
  logic [LENGTH_BITS-1:0]  hit_count;
  logic [INDEX_BITS-1:0]   hit_start;

  rof_result_t expected_hits[$];

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic logic [7:0] pattern_byte(input int k);
    return pattern_bytes[k*8 +: 8];
  endfunction

  // Closing a search always leaves the finder idle until the next first beat.
  function automatic rof_result_t close_search(input logic hit,
                                               input logic [INDEX_BITS-1:0] pos,
                                               input logic [LENGTH_BITS-1:0] len);
    rof_result_t r;
    r = '0;
    r.emit = 1'b1;
    r.found = hit;
    r.position = pos;
    r.length = len;
    searching = 1'b0;
    return r;
  endfunction

  function automatic rof_result_t scan_beat(input rof_item_t beat);
    rof_result_t none;
    logic [INDEX_BITS-1:0] here;
    logic [LENGTH_BITS-1:0] need;
    logic [LENGTH_BITS-1:0] span;
    int len;
    int k;
    none = '0;
    if (beat.first) begin
      searching = 1'b1;
      next_pos = beat.start_index;
      hit_count = '0;
      hit_start = '0;
    end
    if (!searching) return none;
    here = next_pos;
    next_pos = next_pos + 1'b1;
    if (search_kind == MODE_RUN) begin
      need = (least_run == 0) ? 16'd1 : least_run;
      if (beat.symbol == pattern_byte(0)) begin
        if (hit_count == 0) hit_start = here;
        if (hit_count != 16'hFFFF) hit_count = hit_count + 1'b1;
        if (beat.last && hit_count >= need) return close_search(1'b1, hit_start, hit_count);
      end else if (hit_count != 0) begin
        if (hit_count >= need) return close_search(1'b1, hit_start, hit_count);
        hit_count = '0;
      end
    end else begin
      len = (pat_len_reg == 0) ? 1 :
            (pat_len_reg > PATTERN_SLOTS) ? PATTERN_SLOTS : int'(pat_len_reg);
      // A broken partial match is not backtracked, but the breaking
      // character may itself open a new match.
      k = (hit_count < len) ? int'(hit_count) : 0;
      if (beat.symbol == pattern_byte(k)) begin
        if (k == 0) hit_start = here;
        hit_count = 16'(k + 1);
      end else begin
        hit_count = '0;
        if (beat.symbol == pattern_byte(0)) begin
          hit_start = here;
          hit_count = 16'd1;
        end
      end
      span = len[15:0];
      if (hit_count == span) return close_search(1'b1, hit_start, span);
    end
    if (beat.last) return close_search(1'b0, '0, '0);
    return none;
  endfunction

  always @(posedge clk) begin
    rof_item_t beat;
    rof_result_t want;
    rof_result_t hit;
    if (rst) begin
      search_kind = MODE_RUN;
      least_run = 16'd1;
      pat_len_reg = 5'd1;
      pattern_bytes = '0;
      searching = 1'b0;
      next_pos = '0;
      hit_count = '0;
      hit_start = '0;
      expected_hits.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SEARCH_MODE:    search_kind = rof_mode_t'(cfg_data[0]);
          REG_MIN_RUN:        least_run = cfg_data[15:0];
          REG_PATTERN_LENGTH: pat_len_reg = cfg_data[4:0];
          REG_PATTERN_LOW:    pattern_bytes[63:0] = cfg_data;
          REG_PATTERN_HIGH:   pattern_bytes[127:64] = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          report_mismatch("result beat with nothing expected, position",
                          match_position, '0);
        end else begin
          want = expected_hits.pop_front();
          if (found !== want.found)
            report_mismatch("found", 32'(found), 32'(want.found));
          if (match_position !== want.position)
            report_mismatch("match_position", match_position, want.position);
          if (match_length !== want.length)
            report_mismatch("match_length", 32'(match_length), 32'(want.length));
        end
      end
      if (in_valid && !in_stall) begin
        beat.symbol = symbol;
        beat.first = first;
        beat.last = last;
        beat.start_index = start_index;
        hit = scan_beat(beat);
        if (hit.emit) expected_hits.push_back(hit);
      end
    end
    outstanding = expected_hits.size();
  end

endmodule

/* test/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rof_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 116;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic [SYMBOL_BITS-1:0]    symbol;
  logic                      first;
  logic                      last;
  logic [INDEX_BITS-1:0]     start_index;
  logic                      out_valid;
  logic                      out_stall;
  logic                      found;
  logic [INDEX_BITS-1:0]     match_position;
  logic [LENGTH_BITS-1:0]    match_length;
  int                        mismatches;
  int                        outstanding;

  // Stimulus-side view of the current settings, used to shape streams.
  rof_mode_t        cur_mode;
  logic [15:0]      cur_need;
  int               cur_used;
  logic [127:0]     cur_pattern;
  logic             tx_calm;
  logic             rx_calm;
  logic             hold_req;
  int               quiet_cycles = 0;

  run_or_pattern_finder_unit dut (.*);

  match_checker u_match_checker (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .symbol(symbol),
    .first(first), .last(last), .start_index(start_index), .out_valid(out_valid),
    .out_stall(out_stall), .found(found), .match_position(match_position),
    .match_length(match_length), .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold-off on request.
  initial begin
    int stall_left;
    int r;
    bit held;
    out_stall = 1'b0;
    rx_calm = 1'b0;
    stall_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
      if (hold_req && !held) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!rx_calm) begin
          r = $urandom_range(0, 99);
          if (r < 20) stall_left = $urandom_range(1, 3);
          else if (r < 24) stall_left = $urandom_range(5, 15);
          else if (r == 24) stall_left = $urandom_range(20, 60);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [127:0] make_pattern(input logic few_letters);
    logic [127:0] p;
    logic [7:0] letters[3];
    foreach (letters[i]) letters[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < 16; i++)
      p[i*8 +: 8] = few_letters ? letters[$urandom_range(0, 2)] : 8'($urandom_range(0, 255));
    return p;
  endfunction

  // Starts and ends at a falling edge; valid stays high when no gap follows.
  task automatic send_beat(input logic [7:0] sym, input logic f, input logic l,
                           input logic [31:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    symbol <= sym;
    first <= f;
    last <= l;
    start_index <= idx;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic put_reg(input rof_reg_t r, input logic [63:0] v);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(negedge clk);
  endtask

  // Unused upper bits of the narrow registers carry random junk.
  task automatic set_config(input rof_mode_t m, input logic [15:0] need,
                            input logic [4:0] plen, input logic [127:0] pat);
    logic [63:0] v;
    v = {$urandom, $urandom};
    v[0] = m;
    put_reg(REG_SEARCH_MODE, v);
    v = {$urandom, $urandom};
    v[15:0] = need;
    put_reg(REG_MIN_RUN, v);
    v = {$urandom, $urandom};
    v[4:0] = plen;
    put_reg(REG_PATTERN_LENGTH, v);
    put_reg(REG_PATTERN_LOW, pat[63:0]);
    put_reg(REG_PATTERN_HIGH, pat[127:64]);
    cfg_write <= 1'b0;
    cur_mode = m;
    cur_need = need;
    cur_used = (plen == 0) ? 1 : (plen > 16) ? 16 : int'(plen);
    cur_pattern = pat;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One search stream built from runs, whole patterns, prefixes and noise.
  task automatic send_stream(output int count);
    logic [7:0] body[$];
    logic [7:0] run_char;
    int target;
    int runlen;
    int n;
    logic f;
    logic l;
    logic [31:0] idx;
    run_char = cur_pattern[7:0];
    target = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 90);
    while (body.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          if (cur_mode == MODE_RUN) begin
            if (cur_need > 38) runlen = $urandom_range(1, 40);
            else runlen = $urandom_range((cur_need > 1) ? cur_need - 1 : 1, cur_need + 1);
            repeat (runlen) body.push_back(run_char);
          end else begin
            for (int i = 0; i < cur_used; i++) body.push_back(cur_pattern[i*8 +: 8]);
          end
        end
        3, 4: begin
          n = $urandom_range(1, (cur_mode == MODE_RUN) ? 3 : cur_used);
          for (int i = 0; i < n; i++)
            body.push_back((cur_mode == MODE_RUN) ? run_char : cur_pattern[i*8 +: 8]);
        end
        5, 6, 7: body.push_back(cur_pattern[$urandom_range(0, cur_used - 1)*8 +: 8]);
        8: body.push_back(8'($urandom_range(0, 255)));
        default: begin
          body.push_back(run_char);
          body.push_back(run_char);
        end
      endcase
    end
    for (int i = 0; i < body.size(); i++) begin
      f = (i == 0) || ($urandom_range(0, 49) == 0);
      idx = (f && $urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40) : $urandom;
      l = (i == body.size() - 1) ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 59) == 0);
      send_beat(body[i], f, l, idx);
    end
    count = body.size();
  endtask

  initial begin
    logic [127:0] pat;
    int sent;
    int n;
    logic pressed;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    symbol = '0;
    first = 1'b0;
    last = 1'b0;
    start_index = '0;
    tx_calm = 1'b0;
    hold_req = 1'b0;
    pressed = 1'b0;
    cur_mode = MODE_RUN;
    cur_need = 16'd1;
    cur_used = 1;
    cur_pattern = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Settings after reset: runs of 0x00, one character is enough.
    send_beat(8'h00, 1'b0, 1'b0, 32'd5);
    send_beat(8'h00, 1'b1, 1'b0, 32'hFFFF_FFFE);
    send_beat(8'h00, 1'b0, 1'b0, $urandom);
    send_beat(8'h00, 1'b0, 1'b0, $urandom);
    send_beat(8'hFF, 1'b0, 1'b0, $urandom);
    send_beat(8'h00, 1'b0, 1'b1, $urandom);
    send_beat(8'h00, 1'b1, 1'b0, 32'h10);
    send_beat(8'h00, 1'b1, 1'b0, 32'h20);
    send_beat(8'h5A, 1'b0, 1'b1, $urandom);
    drain();

    pat = {$urandom, $urandom, $urandom, $urandom};
    pat[7:0] = 8'hFF;
    set_config(MODE_RUN, 16'd0, 5'd1, pat);
    send_beat(8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_beat(8'h12, 1'b1, 1'b1, 32'd7);
    drain();

    // A run of two falls short of three; the run that reaches the end counts.
    pat[7:0] = 8'hA5;
    set_config(MODE_RUN, 16'd3, 5'd1, pat);
    send_beat(8'hA5, 1'b1, 1'b0, 32'd100);
    send_beat(8'hA5, 1'b0, 1'b0, $urandom);
    send_beat(8'h00, 1'b0, 1'b0, $urandom);
    send_beat(8'hA5, 1'b0, 1'b0, $urandom);
    send_beat(8'hA5, 1'b0, 1'b0, $urandom);
    send_beat(8'hA5, 1'b0, 1'b1, $urandom);
    drain();

    // Pattern "AAB": in "AAAB" the third A breaks the match and restarts it.
    pat[23:0] = 24'h424141;
    set_config(MODE_EXACT, 16'd3, 5'd3, pat);
    send_beat(8'h41, 1'b1, 1'b0, 32'd0);
    send_beat(8'h41, 1'b0, 1'b0, $urandom);
    send_beat(8'h41, 1'b0, 1'b0, $urandom);
    send_beat(8'h42, 1'b0, 1'b1, $urandom);
    send_beat(8'h41, 1'b1, 1'b0, 32'd50);
    send_beat(8'h41, 1'b0, 1'b0, $urandom);
    send_beat(8'h42, 1'b0, 1'b1, $urandom);
    drain();

    for (int p = 0; p < 11; p++) begin
      case (p)
        0:  set_config(MODE_RUN, 16'd1, 5'($urandom_range(0, 31)), make_pattern(1'b1));
        1:  set_config(MODE_RUN, 16'($urandom_range(2, 5)), 5'($urandom_range(0, 31)),
                       make_pattern(1'b1));
        2:  set_config(MODE_EXACT, 16'($urandom), 5'd0, make_pattern(1'b1));
        3:  set_config(MODE_EXACT, 16'($urandom), 5'd1, make_pattern(1'b1));
        4:  set_config(MODE_EXACT, 16'($urandom), 5'($urandom_range(2, 6)), make_pattern(1'b1));
        5:  set_config(MODE_EXACT, 16'($urandom), 5'd16, make_pattern(1'b1));
        6:  set_config(MODE_EXACT, 16'($urandom), 5'd31, make_pattern(1'b0));
        7:  set_config(MODE_EXACT, 16'($urandom), 5'($urandom_range(17, 30)),
                       make_pattern(1'b1));
        8:  set_config(MODE_RUN, 16'hFFFF, 5'($urandom_range(0, 31)), make_pattern(1'b0));
        9:  set_config(MODE_EXACT, 16'($urandom), 5'($urandom_range(2, 16)),
                       make_pattern(1'b0));
        default: set_config(MODE_RUN, 16'd0, 5'($urandom_range(0, 31)), make_pattern(1'b1));
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (p == 1 && !pressed && sent >= 30) begin
          hold_req = 1'b1;
          pressed = 1'b1;
        end
        if ($urandom_range(0, 7) == 0) tx_calm = !tx_calm;
        // Stray beats: ignored when idle, absorbed by a search left open.
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 3))
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)), $urandom);
        send_stream(n);
        sent += n;
      end
      // A one-character stream leaves the finder idle before the next settings.
      send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1, $urandom);
      drain();
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
